// ----- src/sre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sre_pkg
// Shared widths, constants and command codes for the stroke rate estimator.
// ----------------------------------------------------------------------------
package sre_pkg;

    localparam int WINDOW      = 8;
    localparam int IVAL_W      = 16;
    localparam int RATE_W      = 24;
    localparam int CNT_W       = 7;
    localparam int HEAD_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W       = $clog2(WINDOW * 65535 + 1);
    localparam int RATE_NUM    = 60000 * 256;
    localparam int NUM_W       = $clog2(RATE_NUM * WINDOW + 1);
    localparam int DIV_CNT_W   = $clog2(NUM_W + 1);

    localparam logic [NUM_W-1:0]  RATE_NUM_VEC = NUM_W'(RATE_NUM);
    localparam logic [RATE_W-1:0] RATE_MAX     = {RATE_W{1'b1}};
    localparam logic [CNT_W-1:0]  FILL_FULL    = CNT_W'(WINDOW);
    localparam logic [HEAD_W-1:0] HEAD_LAST    = HEAD_W'(WINDOW - 1);

    typedef enum logic
    {
        CMD_PUSH  = 1'b0,
        CMD_CLEAR = 1'b1
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/stroke_rate_estimator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stroke_rate_estimator
// Windowed interval history with a running sum; rate = 60000*256*count/sum
// by a serial divider, saturated to 24 bits.
// ----------------------------------------------------------------------------
// sequence: an accepted item passes ST_MUL (numerator), ST_START (divider
//   start), ST_WAIT (serial divider, one quotient bit per cycle) and ST_OUT
//   (result register); ST_WAIT is skipped when the count or the sum is zero
// items are taken only in ST_IDLE, so a new item waits until the last is through;
//   the result register lets the next item enter while a result waits
// reset: history, running sum, write head and fill count clear at once
// ----------------------------------------------------------------------------
module stroke_rate_estimator
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       item_valid,
    output logic                            item_ready,
    input  wire logic                       cmd,
    input  wire logic [sre_pkg::IVAL_W-1:0] interval_ms,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output logic [sre_pkg::RATE_W-1:0]      rate_q8,
    output logic [sre_pkg::CNT_W-1:0]       interval_count
);
    import sre_pkg::*;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic [IVAL_W-1:0]      ring_reg [WINDOW];
    logic [IVAL_W-1:0]      ring_next [WINDOW];
    logic [HEAD_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [NUM_W-1:0]       num_reg, num_next;
    logic                   zero_reg, zero_next;
    logic [RATE_W-1:0]      calc_reg, calc_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   div_start;
    logic                   div_done;
    logic [NUM_W-1:0]       div_quo;
    logic                   accept;

    sre_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (num_reg),
        .den      (sum_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign accept     = item_valid && item_ready;
    assign div_start  = (state_reg == ST_START) && !zero_reg;

    always_comb
    begin
        state_next     = state_reg;
        ring_next      = ring_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        zero_next      = zero_reg;
        calc_next      = calc_reg;
        rate_next      = rate_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_t'(cmd) == CMD_CLEAR)
                    begin
                        for (int i = 0; i < WINDOW; i++)
                        begin
                            ring_next[i] = '0;
                        end
                        head_next = '0;
                        fill_next = '0;
                        sum_next  = '0;
                    end
                    else
                    begin
                        ring_next[head_reg] = interval_ms;
                        sum_next  = sum_reg - SUM_W'(ring_reg[head_reg])
                                    + SUM_W'(interval_ms);
                        head_next = (head_reg == HEAD_LAST) ? '0 : head_reg + 1'b1;
                        fill_next = (fill_reg == FILL_FULL) ? fill_reg : fill_reg + 1'b1;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                num_next   = RATE_NUM_VEC * {{(NUM_W-CNT_W){1'b0}}, fill_reg};
                zero_next  = (fill_reg == '0) || (sum_reg == '0);
                state_next = ST_START;
            end
            ST_START:
            begin
                if (zero_reg)
                begin
                    calc_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    calc_next  = (div_quo > NUM_W'(RATE_MAX)) ? RATE_MAX
                                                              : div_quo[RATE_W-1:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    rate_next      = calc_reg;
                    count_next     = fill_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            head_reg      <= '0;
            fill_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ring_reg      <= ring_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        zero_reg  <= zero_next;
        calc_reg  <= calc_next;
        rate_reg  <= rate_next;
        count_reg <= count_next;
    end

    assign result_valid   = out_valid_reg;
    assign rate_q8        = rate_reg;
    assign interval_count = count_reg;

endmodule

`default_nettype wire

// ----- src/sre_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sre_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sre_divider
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [sre_pkg::NUM_W-1:0] num,
    input  wire logic [sre_pkg::SUM_W-1:0] den,
    output logic                           done,
    output logic [sre_pkg::NUM_W-1:0]      quotient
);
    import sre_pkg::*;

    typedef enum logic
    {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    div_state_t             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SUM_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       den_reg, den_next;
    logic [NUM_W-1:0]       quo_reg, quo_next;
    logic                   done_reg, done_next;
    logic [SUM_W:0]         shifted;
    logic [SUM_W:0]         trial;

    always_comb
    begin
        shifted    = {rem_reg, quo_reg[NUM_W-1]};
        trial      = shifted - {1'b0, den_reg};
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        done_next  = 1'b0;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    rem_next   = '0;
                    den_next   = den;
                    quo_next   = num;
                    cnt_next   = DIV_CNT_W'(NUM_W);
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (shifted >= {1'b0, den_reg})
                begin
                    rem_next = trial[SUM_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = shifted[SUM_W-1:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
